/* sv/sonde_frame_checksum_diff_encoder_macros.svh */
// assertion macros used by the checker file
// no dependencies; take in with `include
`ifndef SONDE_FRAME_CHECKSUM_DIFF_ENCODER_MACROS_SVH
`define SONDE_FRAME_CHECKSUM_DIFF_ENCODER_MACROS_SVH

// clocked property, switched off while reset is asserted
`define SFCDE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked property that also holds during reset
`define SFCDE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/sfcde_pkg.sv */
// shared types, codes and reset values of the sonde frame encoder
// no dependencies
package sfcde_pkg;

    localparam int RESULTS_MAX      = 21;
    localparam int SYNC_BYTES       = 4;
    localparam int CKS_BYTES        = 2;
    localparam int MAX_PREAMBLE_DEF = 16;

    // preamble count and per-item word step widths
    localparam int PRE_W  = 5;
    localparam int STEP_W = 5;

    // preamble room left inside the per-item word budget
    localparam logic [PRE_W-1:0] ROOM_BODY = PRE_W'(RESULTS_MAX - SYNC_BYTES - 1);
    localparam logic [PRE_W-1:0] ROOM_LAST =
        PRE_W'(RESULTS_MAX - SYNC_BYTES - 1 - CKS_BYTES);

    // queue between front and back; depth is a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // register port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_PRE_LEN  = 3'd0,
        REG_PRE_VAL  = 3'd1,
        REG_SYNC     = 3'd2,
        REG_INIT_LVL = 3'd3,
        REG_ENC_EN   = 3'd4
    } reg_idx_t;

    localparam logic [PRE_W-1:0] PRE_LEN_RST  = PRE_W'(16);
    localparam logic [7:0]       PRE_VAL_RST  = 8'h99;
    localparam logic [31:0]      SYNC_RST     = 32'h9999_4C99;
    localparam logic             INIT_LVL_RST = 1'b1;
    localparam logic             ENC_EN_RST   = 1'b1;

    // word kinds
    localparam logic [1:0] KIND_PRE  = 2'd0;
    localparam logic [1:0] KIND_SYNC = 2'd1;
    localparam logic [1:0] KIND_BODY = 2'd2;
    localparam logic [1:0] KIND_CKS  = 2'd3;

    typedef struct packed {
        logic [PRE_W-1:0] pre_len;
        logic [7:0]       pre_val;
        logic [31:0]      sync_word;
        logic             init_level;
        logic             enc_en;
    } cfg_t;

    typedef struct packed {
        logic [7:0]       data;
        logic             last;
        logic             open;
        logic [PRE_W-1:0] pre_cnt;
    } qent_t;

endpackage

/* sv/sfcde_regs.sv */
// configuration registers behind the apb-style port
// depends on sfcde_pkg
module sfcde_regs (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [sfcde_pkg::ADDR_W-1:0] paddr,
    input  logic [sfcde_pkg::DATA_W-1:0] pwdata,
    output logic [sfcde_pkg::DATA_W-1:0] prdata,
    output logic                     pready,
    output sfcde_pkg::cfg_t          cfg
);
    import sfcde_pkg::*;

    logic [PRE_W-1:0] pre_len_reg, pre_len_next;
    logic [7:0]       pre_val_reg, pre_val_next;
    logic [31:0]      sync_reg, sync_next;
    logic             init_lvl_reg, init_lvl_next;
    logic             enc_en_reg, enc_en_next;
    logic [2:0]       idx;
    logic             wr;

    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        pre_len_next  = pre_len_reg;
        pre_val_next  = pre_val_reg;
        sync_next     = sync_reg;
        init_lvl_next = init_lvl_reg;
        enc_en_next   = enc_en_reg;
        if (wr)
        begin
            unique case (idx)
                REG_PRE_LEN:  pre_len_next  = pwdata[PRE_W-1:0];
                REG_PRE_VAL:  pre_val_next  = pwdata[7:0];
                REG_SYNC:     sync_next     = pwdata[31:0];
                REG_INIT_LVL: init_lvl_next = pwdata[0];
                REG_ENC_EN:   enc_en_next   = pwdata[0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_PRE_LEN:  prdata = DATA_W'(pre_len_reg);
            REG_PRE_VAL:  prdata = DATA_W'(pre_val_reg);
            REG_SYNC:     prdata = DATA_W'(sync_reg);
            REG_INIT_LVL: prdata = DATA_W'(init_lvl_reg);
            REG_ENC_EN:   prdata = DATA_W'(enc_en_reg);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_len_reg  <= PRE_LEN_RST;
            pre_val_reg  <= PRE_VAL_RST;
            sync_reg     <= SYNC_RST;
            init_lvl_reg <= INIT_LVL_RST;
            enc_en_reg   <= ENC_EN_RST;
        end
        else
        begin
            pre_len_reg  <= pre_len_next;
            pre_val_reg  <= pre_val_next;
            sync_reg     <= sync_next;
            init_lvl_reg <= init_lvl_next;
            enc_en_reg   <= enc_en_next;
        end
    end

    assign cfg = '{pre_len: pre_len_reg, pre_val: pre_val_reg, sync_word: sync_reg,
                   init_level: init_lvl_reg, enc_en: enc_en_reg};

endmodule

/* sv/sfcde_front.sv */
// input side: accepts body bytes, marks frame openers, sizes the preamble
// depends on sfcde_pkg
module sfcde_front #(
    parameter int MAX_PREAMBLE = sfcde_pkg::MAX_PREAMBLE_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [7:0]      data_byte,
    input  logic            last_in,
    input  sfcde_pkg::cfg_t cfg,
    input  logic            q_full,
    output logic            push,
    output sfcde_pkg::qent_t push_ent
);
    import sfcde_pkg::*;

    localparam logic [PRE_W:0] MAXP = (PRE_W + 1)'(MAX_PREAMBLE);

    logic             inside_reg, inside_next;
    logic [PRE_W:0]   pl_wide;
    logic [PRE_W-1:0] room;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    // preamble length clamped to the parameter and to the word budget
    always_comb
    begin
        room    = last_in ? ROOM_LAST : ROOM_BODY;
        pl_wide = {1'b0, cfg.pre_len};
        if (pl_wide > MAXP)
            pl_wide = MAXP;
        if (pl_wide > {1'b0, room})
            pl_wide = {1'b0, room};
    end

    assign push_ent = '{data: data_byte, last: last_in, open: !inside_reg,
                        pre_cnt: pl_wide[PRE_W-1:0]};

    assign inside_next = push ? !last_in : inside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inside_reg <= 1'b0;
        else
            inside_reg <= inside_next;
    end

endmodule

/* sv/sfcde_queue.sv */
// short queue of classified bytes between front and back
// depends on sfcde_pkg
module sfcde_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sfcde_pkg::qent_t push_ent,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output sfcde_pkg::qent_t head
);
    import sfcde_pkg::*;

    qent_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_ent;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* sv/sfcde_back.sv */
// output sequencer: preamble, sync, coded body and checksum words
// depends on sfcde_pkg
module sfcde_back (
    input  logic             clk,
    input  logic             rst_n,
    input  sfcde_pkg::cfg_t  cfg,
    input  logic             head_valid,
    input  sfcde_pkg::qent_t head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_byte,
    output logic [1:0]       byte_kind,
    output logic             last_out
);
    import sfcde_pkg::*;

    typedef enum logic [2:0] {
        PH_PRE,
        PH_SYNC,
        PH_BODY,
        PH_CKHI,
        PH_CKLO
    } phase_t;

    function automatic logic [15:0] cks_update(logic [15:0] c, logic [7:0] b);
        logic [7:0] rb;
        logic [7:0] t;
        logic [7:0] s;
        rb = {b[0], b[7:1]};
        rb = rb ^ (rb >> 2);
        t  = {c[1] ^ c[3] ^ c[5], c[0] ^ c[2] ^ c[4], c[5:0]};
        s  = c[14:7];
        s  = s ^ (s >> 2);
        return {c[7:0], rb ^ t ^ s};
    endfunction

    // returns {level after last bit, coded byte}; raw and level kept when off
    function automatic logic [8:0] line_code(logic [7:0] v, logic lvl, logic en);
        logic [7:0] r;
        logic       l;
        l = lvl;
        r = '0;
        for (int j = 7; j >= 0; j--)
        begin
            if (!v[j])
                l = ~l;
            r[j] = l;
        end
        return en ? {l, r} : {lvl, v};
    endfunction

    logic [STEP_W-1:0] step_reg, step_next;
    logic [15:0]       cks_reg, cks_next;
    logic              level_reg, level_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic [1:0]        kind_reg, kind_next;
    logic              last_reg, last_next;

    logic [STEP_W-1:0] npre;
    logic [STEP_W-1:0] body_pos;
    logic [STEP_W-1:0] final_pos;
    logic [1:0]        sync_idx;
    logic [7:0]        sync_byte;
    logic [8:0]        coded;
    logic [7:0]        code_in;
    phase_t            phase;
    logic              load;
    logic              emit;

    // position of the current word within the head item's words
    always_comb
    begin
        npre      = head.open ? STEP_W'(head.pre_cnt) : '0;
        body_pos  = npre + (head.open ? STEP_W'(SYNC_BYTES) : '0);
        final_pos = body_pos + (head.last ? STEP_W'(CKS_BYTES) : '0);
        sync_idx  = 2'(step_reg - npre);
        if (step_reg < npre)
            phase = PH_PRE;
        else if (step_reg < body_pos)
            phase = PH_SYNC;
        else if (step_reg == body_pos)
            phase = PH_BODY;
        else if (step_reg == body_pos + 1'b1)
            phase = PH_CKHI;
        else
            phase = PH_CKLO;
    end

    always_comb
    begin
        case (sync_idx)
            2'd0:    sync_byte = cfg.sync_word[31:24];
            2'd1:    sync_byte = cfg.sync_word[23:16];
            2'd2:    sync_byte = cfg.sync_word[15:8];
            default: sync_byte = cfg.sync_word[7:0];
        endcase
    end

    always_comb
    begin
        case (phase)
            PH_CKHI: code_in = cks_reg[15:8];
            PH_CKLO: code_in = cks_reg[7:0];
            default: code_in = head.data;
        endcase
        coded = line_code(code_in, level_reg, cfg.enc_en);
    end

    assign load = !out_valid_reg || !out_stall;
    assign emit = head_valid && load;
    assign pop  = emit && (step_reg == final_pos);

    always_comb
    begin
        step_next      = step_reg;
        cks_next       = cks_reg;
        level_next     = level_reg;
        out_valid_next = load ? head_valid : out_valid_reg;
        out_byte_next  = out_byte_reg;
        kind_next      = kind_reg;
        last_next      = last_reg;
        if (emit)
        begin
            step_next = pop ? '0 : step_reg + 1'b1;
            last_next = 1'b0;
            unique case (phase)
                PH_PRE:
                begin
                    out_byte_next = cfg.pre_val;
                    kind_next     = KIND_PRE;
                end
                PH_SYNC:
                begin
                    out_byte_next = sync_byte;
                    kind_next     = KIND_SYNC;
                    // frame state restarts as the header closes
                    if (sync_idx == 2'(SYNC_BYTES - 1))
                    begin
                        cks_next   = '0;
                        level_next = cfg.init_level;
                    end
                end
                PH_BODY:
                begin
                    out_byte_next = coded[7:0];
                    kind_next     = KIND_BODY;
                    level_next    = coded[8];
                    cks_next      = cks_update(cks_reg, head.data);
                end
                PH_CKHI:
                begin
                    out_byte_next = coded[7:0];
                    kind_next     = KIND_CKS;
                    level_next    = coded[8];
                end
                PH_CKLO:
                begin
                    out_byte_next = coded[7:0];
                    kind_next     = KIND_CKS;
                    level_next    = coded[8];
                    last_next     = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            cks_reg       <= '0;
            level_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            cks_reg       <= cks_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        kind_reg     <= kind_next;
        last_reg     <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign byte_kind = kind_reg;
    assign last_out  = last_reg;

endmodule

/* sv/sonde_frame_checksum_diff_encoder.sv */
// sonde frame framer top level: register port, front, queue and back sequencer
// depends on sfcde_pkg, sfcde_regs, sfcde_front, sfcde_queue, sfcde_back
//
// input channel (in_valid/in_stall) takes one frame body byte per word with
// last_in on the final byte. output channel (out_valid/out_stall) gives one
// line word per cycle while not stalled, with its kind and a last flag on the
// low checksum byte. the first body byte of a frame expands to the preamble
// run (clamped to MAX_PREAMBLE and to 16, or 14 for a one-byte frame), four
// raw sync bytes and the coded body byte; a last byte adds the two coded
// checksum bytes. an accepted byte is written into the queue and then into
// the output register. the back sequencer puts out one word per cycle while
// it holds a queued byte and is not stalled, so a body byte inside a frame
// costs one word, a frame opener preamble+5 words and a last byte 2 more;
// the 4-entry queue absorbs the burst while the front keeps taking bytes.
// when out_stall is high the output register holds its word and the sequencer
// waits; in_stall rises only when the queue is full.
// reset clears the queue, the frame state and the output valid, and loads the
// registers with their defaults; registers are written through psel/penable
module sonde_frame_checksum_diff_encoder #(
    parameter int MAX_PREAMBLE = sfcde_pkg::MAX_PREAMBLE_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sfcde_pkg::ADDR_W-1:0] paddr,
    input  logic [sfcde_pkg::DATA_W-1:0] pwdata,
    output logic [sfcde_pkg::DATA_W-1:0] prdata,
    output logic                         pready,
    // body byte channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   data_byte,
    input  logic                         last_in,
    // line word channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [7:0]                   out_byte,
    output logic [1:0]                   byte_kind,
    output logic                         last_out
);
    import sfcde_pkg::*;

    cfg_t  cfg;
    qent_t push_ent;
    qent_t head;
    logic  push;
    logic  q_full;
    logic  pop;
    logic  head_valid;

    sfcde_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // front: marks frame openers and sizes their preamble
    sfcde_front #(
        .MAX_PREAMBLE (MAX_PREAMBLE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_in   (last_in),
        .cfg       (cfg),
        .q_full    (q_full),
        .push      (push),
        .push_ent  (push_ent)
    );

    // decouples byte intake from the multi-word frame header
    sfcde_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ent   (push_ent),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // back: checksum, line code and the registered output word
    sfcde_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .byte_kind  (byte_kind),
        .last_out   (last_out)
    );

endmodule

/* sv/sfcde_checker.sv */
// port-level checks of the sonde frame encoder, bound to the top level
// depends on sfcde_pkg and the assertion macro header
`include "sonde_frame_checksum_diff_encoder_macros.svh"

module sfcde_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic [1:0] byte_kind,
    input logic       last_out
);
    import sfcde_pkg::*;

    // a stalled word holds
    `SFCDE_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(byte_kind) && $stable(last_out), "stalled word changed")

    // only a checksum word carries the last flag
    `SFCDE_ASSERT(a_last_kind, clk, rst_n, out_valid && last_out |-> byte_kind == KIND_CKS, "last flag on a non checksum word")

    // a preamble word is followed by preamble or sync
    `SFCDE_ASSERT(a_pre_order, clk, rst_n, (out_valid && !out_stall && byte_kind == KIND_PRE) ##1 out_valid |-> byte_kind == KIND_PRE || byte_kind == KIND_SYNC, "preamble not followed by sync")

    // a sync word is followed by sync or the first body byte
    `SFCDE_ASSERT(a_sync_order, clk, rst_n, (out_valid && !out_stall && byte_kind == KIND_SYNC) ##1 out_valid |-> byte_kind == KIND_SYNC || byte_kind == KIND_BODY, "sync not followed by body")

    // no word is offered while reset is held
    `SFCDE_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !out_valid, "output valid during reset")

endmodule

bind sonde_frame_checksum_diff_encoder sfcde_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .byte_kind (byte_kind),
    .last_out  (last_out)
);
